[rtl/mpb_pkg.sv]
// ----------------------------------------------------------------------------
// mpb_pkg
// Shared types and constants of the multipart body parser: channel beats,
// controller command and datapath status groups, event codes, characters.
// ----------------------------------------------------------------------------
package mpb_pkg;

  // Boundary table depth and register widths
  localparam int MAX_BOUNDARY = 32;
  localparam int LEN_W        = 6;
  localparam int POS_W        = 6;

  // Input beat opcodes
  localparam logic OP_PARSE = 1'b0;
  localparam logic OP_LOAD  = 1'b1;

  // Event kinds
  localparam logic [2:0] EV_PART_BEGIN = 3'd0;
  localparam logic [2:0] EV_NAME       = 3'd1;
  localparam logic [2:0] EV_VALUE      = 3'd2;
  localparam logic [2:0] EV_HDRS_DONE  = 3'd3;
  localparam logic [2:0] EV_DATA       = 3'd4;
  localparam logic [2:0] EV_PART_END   = 3'd5;
  localparam logic [2:0] EV_BODY_END   = 3'd6;
  localparam logic [2:0] EV_ERROR      = 3'd7;

  // Characters
  localparam logic [7:0] CH_CR       = 8'd13;
  localparam logic [7:0] CH_LF       = 8'd10;
  localparam logic [7:0] CH_HYPHEN   = 8'd45;
  localparam logic [7:0] CH_COLON    = 8'd58;
  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] CH_UP_A     = 8'd65;
  localparam logic [7:0] CH_UP_Z     = 8'd90;
  localparam logic [7:0] CH_LO_A     = 8'd97;
  localparam logic [7:0] CH_LO_Z     = 8'd122;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  // Input and result beats
  typedef struct packed {
    logic       opcode;
    logic [7:0] byte_value;
    logic [4:0] boundary_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [7:0] event_byte;
    logic       last_of_run;
  } out_item_t;

  // Counter operations
  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_CLR  = 2'd1,
    CNT_INC  = 2'd2
  } cnt_op_t;

  // Source of the event byte
  typedef enum logic [2:0] {
    SRC_ZERO  = 3'd0,
    SRC_BYTE  = 3'd1,
    SRC_LOWER = 3'd2,
    SRC_CR    = 3'd3,
    SRC_LF    = 3'd4,
    SRC_TAB   = 3'd5
  } ev_src_t;

  // Controller to datapath
  typedef struct packed {
    logic       sel_in;
    logic       latch;
    logic       tab_wr;
    cnt_op_t    match_op;
    cnt_op_t    rep_op;
    logic       rd_rep;
    logic       emit;
    logic [2:0] ev_kind;
    ev_src_t    ev_src;
    logic       ev_last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic is_cr;
    logic is_lf;
    logic is_hyphen;
    logic is_colon;
    logic is_space;
    logic is_alpha;
    logic tab_eq;
    logic m_eq_len;
    logic m_eq_len1;
    logic m_gt_len1;
    logic m_ge_len;
    logic m1_eq_len;
    logic m_zero;
    logic rep_last;
  } status_t;

endpackage

[rtl/mpb_dpath.sv]
// ----------------------------------------------------------------------------
// mpb_dpath
// Parser datapath: boundary length register, boundary table memory with a
// prefetched read port, byte latch, match and replay counters, compares and
// the output register.
// ----------------------------------------------------------------------------
module mpb_dpath #(
  parameter int MAX_BOUNDARY = mpb_pkg::MAX_BOUNDARY
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mpb_pkg::in_item_t                in_item,
  input  logic                             cfg_wr_en,
  input  logic [mpb_pkg::LEN_W-1:0]        cfg_wr_data,
  input  mpb_pkg::cmd_t                    cmd,
  output mpb_pkg::status_t                 st,
  output logic                             out_valid,
  input  logic                             out_stall,
  output mpb_pkg::out_item_t               out_item
);

  localparam int AW = (MAX_BOUNDARY > 1) ? $clog2(MAX_BOUNDARY) : 1;
  localparam logic [mpb_pkg::POS_W-1:0] MAX_POS = mpb_pkg::POS_W'(MAX_BOUNDARY);

  logic [mpb_pkg::LEN_W-1:0] len_r;
  logic [mpb_pkg::LEN_W-1:0] len_use;
  logic [7:0]                byte_r;
  logic [7:0]                c;
  logic [7:0]                lc;
  logic                      is_upper;
  logic [mpb_pkg::POS_W-1:0] match_r;
  logic [mpb_pkg::POS_W-1:0] match_nxt;
  logic [mpb_pkg::POS_W-1:0] rep_r;
  logic [mpb_pkg::POS_W-1:0] rep_nxt;
  logic [mpb_pkg::POS_W-1:0] ra_pos;
  logic [AW-1:0]             ra;
  logic [AW-1:0]             wa;
  logic                      ra_ok;
  logic                      wr;
  logic [7:0]                rdata_r;
  logic [7:0]                mem [MAX_BOUNDARY];
  logic                      out_valid_r;
  mpb_pkg::out_item_t        out_item_r;
  mpb_pkg::out_item_t        ev;

  // Hold the boundary length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= mpb_pkg::LEN_W'(1);
    end else if (cfg_wr_en) begin
      len_r <= cfg_wr_data;
    end
  end

  // Clamp the length into 1..MAX_BOUNDARY
  always_comb begin
    if (len_r == '0) begin
      len_use = mpb_pkg::LEN_W'(1);
    end else if (len_r > MAX_POS) begin
      len_use = MAX_POS;
    end else begin
      len_use = len_r;
    end
  end

  // Latch the body byte for steps after the accept cycle
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      byte_r <= in_item.byte_value;
    end
  end

  assign c        = cmd.sel_in ? in_item.byte_value : byte_r;
  assign is_upper = (c >= mpb_pkg::CH_UP_A) && (c <= mpb_pkg::CH_UP_Z);
  assign lc       = is_upper ? c + mpb_pkg::CASE_OFFSET : c;

  // Advance match and replay counters
  always_comb begin
    case (cmd.match_op)
      mpb_pkg::CNT_CLR: match_nxt = '0;
      mpb_pkg::CNT_INC: match_nxt = match_r + mpb_pkg::POS_W'(1);
      default:          match_nxt = match_r;
    endcase
    case (cmd.rep_op)
      mpb_pkg::CNT_CLR: rep_nxt = '0;
      mpb_pkg::CNT_INC: rep_nxt = rep_r + mpb_pkg::POS_W'(1);
      default:          rep_nxt = rep_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= '0;
      rep_r   <= '0;
    end else begin
      match_r <= match_nxt;
      rep_r   <= rep_nxt;
    end
  end

  // Prefetch the table entry the next step needs
  assign ra_pos = cmd.rd_rep ? rep_nxt : match_nxt;
  assign ra_ok  = ra_pos < MAX_POS;
  assign ra     = AW'(ra_pos);
  assign wa     = AW'(in_item.boundary_index);
  assign wr     = cmd.tab_wr && ({1'b0, in_item.boundary_index} < MAX_POS);

  // Boundary table, write-first on a same-address read
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wa] <= in_item.byte_value;
    end
    if (wr && ra_ok && (wa == ra)) begin
      rdata_r <= in_item.byte_value;
    end else if (ra_ok) begin
      rdata_r <= mem[ra];
    end else begin
      rdata_r <= '0;
    end
  end

  // Select the event byte
  always_comb begin
    ev.event_kind  = cmd.ev_kind;
    ev.last_of_run = cmd.ev_last;
    case (cmd.ev_src)
      mpb_pkg::SRC_BYTE:  ev.event_byte = c;
      mpb_pkg::SRC_LOWER: ev.event_byte = lc;
      mpb_pkg::SRC_CR:    ev.event_byte = mpb_pkg::CH_CR;
      mpb_pkg::SRC_LF:    ev.event_byte = mpb_pkg::CH_LF;
      mpb_pkg::SRC_TAB:   ev.event_byte = rdata_r;
      default:            ev.event_byte = '0;
    endcase
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item_r <= ev;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Status toward the controller
  always_comb begin
    st.out_free  = !out_valid_r || !out_stall;
    st.is_cr     = (c == mpb_pkg::CH_CR);
    st.is_lf     = (c == mpb_pkg::CH_LF);
    st.is_hyphen = (c == mpb_pkg::CH_HYPHEN);
    st.is_colon  = (c == mpb_pkg::CH_COLON);
    st.is_space  = (c == mpb_pkg::CH_SPACE);
    st.is_alpha  = is_upper || ((c >= mpb_pkg::CH_LO_A) && (c <= mpb_pkg::CH_LO_Z));
    st.tab_eq    = (rdata_r == c);
    st.m_eq_len  = (match_r == len_use);
    st.m_eq_len1 = ({1'b0, match_r} == ({1'b0, len_use} + 7'd1));
    st.m_gt_len1 = ({1'b0, match_r} > ({1'b0, len_use} + 7'd1));
    st.m_ge_len  = (match_r >= len_use);
    st.m1_eq_len = (({1'b0, match_r} + 7'd1) == {1'b0, len_use});
    st.m_zero    = (match_r == '0);
    st.rep_last  = (({1'b0, rep_r} + 7'd1) == {1'b0, match_r});
  end

endmodule

[rtl/mpb_ctrl.sv]
// ----------------------------------------------------------------------------
// mpb_ctrl
// Parser controller: the parse phase machine, the sticky error flag and the
// sequencer that steps an item, including the replay of a held boundary.
// ----------------------------------------------------------------------------
module mpb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_opcode,
  output logic             in_stall,
  input  mpb_pkg::status_t st,
  output mpb_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    C_IDLE    = 4'b0001,
    C_STEP    = 4'b0010,
    C_REP_LF  = 4'b0100,
    C_REP_TAB = 4'b1000
  } ctrl_state_t;

  typedef enum logic [15:0] {
    PH_START             = 16'h0001,
    PH_START_BOUNDARY    = 16'h0002,
    PH_FIELD_START       = 16'h0004,
    PH_FIELD             = 16'h0008,
    PH_HDRS_ALMOST_DONE  = 16'h0010,
    PH_VALUE_START       = 16'h0020,
    PH_VALUE             = 16'h0040,
    PH_VALUE_ALMOST_DONE = 16'h0080,
    PH_DATA_START        = 16'h0100,
    PH_DATA              = 16'h0200,
    PH_ALMOST_BOUNDARY   = 16'h0400,
    PH_DATA_BOUNDARY     = 16'h0800,
    PH_ALMOST_END        = 16'h1000,
    PH_FINAL_HYPHEN      = 16'h2000,
    PH_PART_END          = 16'h4000,
    PH_END               = 16'h8000
  } phase_t;

  ctrl_state_t       state_r;
  ctrl_state_t       state_nxt;
  phase_t            phase_r;
  phase_t            phase_nxt;
  logic              err_r;
  logic              err_nxt;
  logic              go;
  logic              s_emit;
  logic [2:0]        s_kind;
  mpb_pkg::ev_src_t  s_src;
  logic              s_last;
  phase_t            s_phase;
  mpb_pkg::cnt_op_t  s_match;
  logic              s_done;
  logic              s_rep;
  logic              s_bad;

  // Decode one parse step for the current phase and byte
  always_comb begin
    s_emit  = 1'b0;
    s_kind  = mpb_pkg::EV_ERROR;
    s_src   = mpb_pkg::SRC_ZERO;
    s_last  = 1'b1;
    s_phase = phase_r;
    s_match = mpb_pkg::CNT_HOLD;
    s_done  = 1'b1;
    s_rep   = 1'b0;
    s_bad   = 1'b0;
    if (err_r) begin
      s_emit = 1'b1;
    end else begin
      case (phase_r)
        PH_START: begin
          s_phase = PH_START_BOUNDARY;
          s_match = mpb_pkg::CNT_CLR;
          s_done  = 1'b0;
        end
        PH_START_BOUNDARY: begin
          if (st.m_eq_len) begin
            if (!st.is_cr) s_bad = 1'b1;
            else           s_match = mpb_pkg::CNT_INC;
          end else if (st.m_eq_len1) begin
            if (!st.is_lf) begin
              s_bad = 1'b1;
            end else begin
              s_match = mpb_pkg::CNT_CLR;
              s_emit  = 1'b1;
              s_kind  = mpb_pkg::EV_PART_BEGIN;
              s_phase = PH_FIELD_START;
            end
          end else if (st.m_gt_len1 || !st.tab_eq) begin
            s_bad = 1'b1;
          end else begin
            s_match = mpb_pkg::CNT_INC;
          end
        end
        PH_FIELD_START, PH_FIELD: begin
          s_phase = PH_FIELD;
          if (st.is_cr) begin
            s_phase = PH_HDRS_ALMOST_DONE;
          end else if (st.is_hyphen) begin
            s_emit = 1'b1;
            s_kind = mpb_pkg::EV_NAME;
            s_src  = mpb_pkg::SRC_BYTE;
          end else if (st.is_colon) begin
            s_phase = PH_VALUE_START;
          end else if (st.is_alpha) begin
            s_emit = 1'b1;
            s_kind = mpb_pkg::EV_NAME;
            s_src  = mpb_pkg::SRC_LOWER;
          end else begin
            s_bad = 1'b1;
          end
        end
        PH_HDRS_ALMOST_DONE: begin
          if (!st.is_lf) s_bad = 1'b1;
          else           s_phase = PH_DATA_START;
        end
        PH_VALUE_START, PH_VALUE: begin
          // skip leading spaces, then take value bytes
          if (!(st.is_space && (phase_r == PH_VALUE_START))) begin
            if (st.is_cr) begin
              s_phase = PH_VALUE_ALMOST_DONE;
            end else begin
              s_phase = PH_VALUE;
              s_emit  = 1'b1;
              s_kind  = mpb_pkg::EV_VALUE;
              s_src   = mpb_pkg::SRC_BYTE;
            end
          end
        end
        PH_VALUE_ALMOST_DONE: begin
          if (!st.is_lf) s_bad = 1'b1;
          else           s_phase = PH_FIELD_START;
        end
        PH_DATA_START: begin
          s_emit  = 1'b1;
          s_kind  = mpb_pkg::EV_HDRS_DONE;
          s_last  = st.is_cr;
          s_phase = st.is_cr ? PH_ALMOST_BOUNDARY : PH_DATA;
          s_done  = st.is_cr;
        end
        PH_DATA: begin
          if (st.is_cr) begin
            s_phase = PH_ALMOST_BOUNDARY;
          end else begin
            s_emit = 1'b1;
            s_kind = mpb_pkg::EV_DATA;
            s_src  = mpb_pkg::SRC_BYTE;
          end
        end
        PH_ALMOST_BOUNDARY: begin
          if (st.is_lf) begin
            s_phase = PH_DATA_BOUNDARY;
            s_match = mpb_pkg::CNT_CLR;
          end else begin
            // release the held CR, then treat the byte as data unless it is another CR
            s_emit  = 1'b1;
            s_kind  = mpb_pkg::EV_DATA;
            s_src   = mpb_pkg::SRC_CR;
            s_last  = st.is_cr;
            s_phase = st.is_cr ? PH_ALMOST_BOUNDARY : PH_DATA;
            s_done  = st.is_cr;
          end
        end
        PH_DATA_BOUNDARY: begin
          if (st.m_ge_len || !st.tab_eq) begin
            // mismatch: release CR now, LF and table bytes follow
            s_emit = 1'b1;
            s_kind = mpb_pkg::EV_DATA;
            s_src  = mpb_pkg::SRC_CR;
            s_last = 1'b0;
            s_done = 1'b0;
            s_rep  = 1'b1;
          end else begin
            s_match = mpb_pkg::CNT_INC;
            if (st.m1_eq_len) begin
              s_emit  = 1'b1;
              s_kind  = mpb_pkg::EV_PART_END;
              s_phase = PH_ALMOST_END;
            end
          end
        end
        PH_ALMOST_END: begin
          if (st.is_hyphen)  s_phase = PH_FINAL_HYPHEN;
          else if (st.is_cr) s_phase = PH_PART_END;
          else               s_bad = 1'b1;
        end
        PH_FINAL_HYPHEN: begin
          if (st.is_hyphen) begin
            s_emit  = 1'b1;
            s_kind  = mpb_pkg::EV_BODY_END;
            s_phase = PH_END;
          end else begin
            s_bad = 1'b1;
          end
        end
        PH_PART_END: begin
          if (st.is_lf) begin
            s_emit  = 1'b1;
            s_kind  = mpb_pkg::EV_PART_BEGIN;
            s_phase = PH_FIELD_START;
          end else begin
            s_bad = 1'b1;
          end
        end
        default: begin
          s_done = 1'b1;
        end
      endcase
      if (s_bad) begin
        s_emit  = 1'b1;
        s_kind  = mpb_pkg::EV_ERROR;
        s_src   = mpb_pkg::SRC_ZERO;
        s_last  = 1'b1;
        s_done  = 1'b1;
        s_rep   = 1'b0;
        s_match = mpb_pkg::CNT_HOLD;
      end
    end
  end

  // Sequence the item and drive datapath commands
  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    err_nxt      = err_r;
    go           = 1'b0;
    in_stall     = !((state_r == C_IDLE) && st.out_free);
    cmd.sel_in   = 1'b0;
    cmd.latch    = 1'b0;
    cmd.tab_wr   = 1'b0;
    cmd.match_op = mpb_pkg::CNT_HOLD;
    cmd.rep_op   = mpb_pkg::CNT_HOLD;
    cmd.rd_rep   = 1'b0;
    cmd.emit     = 1'b0;
    cmd.ev_kind  = s_kind;
    cmd.ev_src   = s_src;
    cmd.ev_last  = s_last;

    case (state_r)
      C_IDLE: begin
        cmd.sel_in = 1'b1;
        if (in_valid && !in_stall) begin
          if (in_opcode == mpb_pkg::OP_LOAD) begin
            cmd.tab_wr = 1'b1;
          end else begin
            cmd.latch = 1'b1;
            go        = 1'b1;
          end
        end
      end
      C_STEP: begin
        go = 1'b1;
      end
      C_REP_LF: begin
        cmd.ev_kind = mpb_pkg::EV_DATA;
        cmd.ev_src  = mpb_pkg::SRC_LF;
        cmd.ev_last = st.m_zero && st.is_cr;
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (st.m_zero) begin
            phase_nxt = st.is_cr ? PH_ALMOST_BOUNDARY : PH_DATA;
            state_nxt = st.is_cr ? C_IDLE : C_STEP;
          end else begin
            cmd.rep_op = mpb_pkg::CNT_CLR;
            state_nxt  = C_REP_TAB;
          end
        end
      end
      C_REP_TAB: begin
        cmd.ev_kind = mpb_pkg::EV_DATA;
        cmd.ev_src  = mpb_pkg::SRC_TAB;
        cmd.ev_last = st.rep_last && st.is_cr;
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.rep_op = mpb_pkg::CNT_INC;
          if (st.rep_last) begin
            phase_nxt = st.is_cr ? PH_ALMOST_BOUNDARY : PH_DATA;
            state_nxt = st.is_cr ? C_IDLE : C_STEP;
          end
        end
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase

    // Commit a parse step once its result beat has room
    if (go && (!s_emit || st.out_free)) begin
      cmd.emit     = s_emit;
      cmd.match_op = s_match;
      phase_nxt    = s_phase;
      if (s_emit && (s_kind == mpb_pkg::EV_ERROR)) begin
        err_nxt = 1'b1;
      end
      if (s_rep)       state_nxt = C_REP_LF;
      else if (s_done) state_nxt = C_IDLE;
      else             state_nxt = C_STEP;
    end

    // Keep the table read on the replay counter while replaying
    cmd.rd_rep = (state_nxt == C_REP_TAB);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      phase_r <= PH_START;
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      err_r   <= err_nxt;
    end
  end

  // Checks
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |=> err_r)
    else $error("error flag cleared without reset");

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> st.out_free)
    else $error("result beat loaded while output register is blocked");

  a_replay_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == C_REP_LF || state_r == C_REP_TAB) |-> phase_r == PH_DATA_BOUNDARY)
    else $error("boundary replay outside boundary match");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.ev_kind == mpb_pkg::EV_ERROR) |-> (cmd.ev_last && state_nxt == C_IDLE))
    else $error("error beat is not the final beat of its item");

endmodule

[rtl/multipart_body_parser.sv]
// ----------------------------------------------------------------------------
// multipart_body_parser
// Byte-serial multipart body parser: opening boundary check, lowercased header
// names, header values, part data pass-through, part and body end detection.
//
// Usage: load the boundary bytes with opcode 1 beats (boundary_index picks the
// table entry), write boundary_length on cfg_wr_en while idle, then stream the
// body as opcode 0 beats. Each body byte gives zero or more result beats; the
// last beat of a byte carries last_of_run. Load beats give no result.
// The first result of a byte is loaded in its accept cycle; the first body byte
// takes an extra step through the start phase. One byte per cycle is accepted
// while out_stall is low and each byte gives at most one result; each extra
// result holds the input side for a further step. A broken-off boundary match
// at position m releases the held CR, LF and m table bytes (read one a cycle
// from the table memory while out_stall is low), then reprocesses the byte as
// data unless it is a CR. The input side frees once the last result is loaded.
// Reset (synchronous) returns to the start phase, clears the error flag and
// sets the length to 1; the table keeps its contents and needs reloading.
// A stall on out_stall holds the result beat and stalls the input channel.
// ----------------------------------------------------------------------------
module multipart_body_parser #(
  parameter int MAX_BOUNDARY = mpb_pkg::MAX_BOUNDARY
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  mpb_pkg::in_item_t         in_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output mpb_pkg::out_item_t        out_item,
  input  logic                      cfg_wr_en,
  input  logic [mpb_pkg::LEN_W-1:0] cfg_wr_data
);

  mpb_pkg::cmd_t    cmd;
  mpb_pkg::status_t st;

  // Phase machine and sequencer
  mpb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_item.opcode),
    .in_stall  (in_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // Table, counters, compares and output register
  mpb_dpath #(
    .MAX_BOUNDARY (MAX_BOUNDARY)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_item     (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .st          (st),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule
